// ===== design/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the traffic rate meter: opcodes, controller
// states, field widths and the packed result layout.
// ----------------------------------------------------------------------------
package trm_pkg;

    localparam int OP_W    = 3;
    localparam int CH_W    = 2;
    localparam int BYTES_W = 32;
    localparam int TOTAL_W = 64;
    localparam int RATE_W  = 32;
    localparam int CONN_W  = 16;

    // opcode + channel + byte count, padded to whole bytes
    localparam int IN_W  = 40;
    localparam int OUT_W = TOTAL_W + RATE_W + RATE_W + CONN_W;

    localparam logic [CONN_W-1:0] CONN_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_TICK  = 3'd1,
        OP_OPEN  = 3'd2,
        OP_CLOSE = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_TICK_RD,
        ST_TICK_CALC,
        ST_TICK_DIV
    } state_t;

    // first member lands in the highest bits, so total_bytes is lowest
    typedef struct packed {
        logic [CONN_W-1:0]  connections;
        logic [RATE_W-1:0]  average_speed;
        logic [RATE_W-1:0]  last_rate;
        logic [TOTAL_W-1:0] total_bytes;
    } result_t;

endpackage

// ===== design/trm_div.sv =====
// ----------------------------------------------------------------------------
// trm_div
// Restoring divider, one quotient bit per cycle. Result is valid in the
// cycle that done is high and holds until the next start.
// ----------------------------------------------------------------------------
module trm_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            quo_next = num;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== design/traffic_rate_meter.sv =====
// ----------------------------------------------------------------------------
// traffic_rate_meter
// Add, open, close and query pass from ST_IDLE through ST_READ and ST_EXEC,
// and m_tvalid is registered as ST_EXEC finishes; a new item is taken only
// back in ST_IDLE, and a result still held on the output stalls ST_EXEC.
// A tick walks all channels through the state memory and the divider
// (ST_TICK_RD, ST_TICK_CALC, ST_TICK_DIV per channel), then reports like a query.
// Reset clears the controller, connection count, history fill and slot and
// the per-channel valid bits; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module traffic_rate_meter #(
    parameter int WINDOW   = 5,
    parameter int CHANNELS = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // opcode[2:0], channel[4:3], byte_count[36:5], zero pad[39:37]
    input  logic [trm_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // total_bytes[63:0], last_rate[95:64], average_speed[127:96],
    // connections[143:128]
    output logic [trm_pkg::OUT_W-1:0] m_tdata
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW   = $clog2(WINDOW + 1);
    localparam int WT_W = trm_pkg::RATE_W + FW;
    localparam int XW   = (CW > trm_pkg::CH_W) ? CW : trm_pkg::CH_W;

    typedef struct packed {
        logic [trm_pkg::TOTAL_W-1:0] total;
        logic [trm_pkg::BYTES_W-1:0] count;
        logic [trm_pkg::RATE_W-1:0]  rate;
        logic [WT_W-1:0]             wsum;
        logic [trm_pkg::RATE_W-1:0]  speed;
    } chan_ent_t;

    // per-channel state and rate history
    chan_ent_t                  chan_mem [0:(1<<CW)-1];
    logic [trm_pkg::RATE_W-1:0] hist_mem [0:(1<<(CW+SW))-1];

    trm_pkg::state_t             state_reg;
    trm_pkg::state_t             state_next;
    logic [trm_pkg::OP_W-1:0]    op_reg;
    logic [trm_pkg::CH_W-1:0]    ch_reg;
    logic [trm_pkg::BYTES_W-1:0] bytes_reg;
    logic [CW-1:0]               c_reg;
    logic [CW-1:0]               c_next;
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;
    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               slot_next;
    logic [trm_pkg::CONN_W-1:0]  open_reg;
    logic [trm_pkg::CONN_W-1:0]  open_next;
    logic [(1<<CW)-1:0]          vld_reg;
    logic                        vld_rd_reg;
    chan_ent_t                   cm_rd_reg;
    logic [trm_pkg::RATE_W-1:0]  hm_rd_reg;
    chan_ent_t                   tick_ent_reg;
    chan_ent_t                   tick_ent_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    trm_pkg::result_t            res_reg;
    trm_pkg::result_t            res_next;

    logic [XW-1:0]               ch_ext;
    logic [CW-1:0]               ch_idx;
    logic                        ch_ok;
    logic                        tick_phase;
    logic [CW-1:0]               cm_raddr;
    logic [CW-1:0]               cm_waddr;
    logic                        cm_we;
    chan_ent_t                   cm_wdata;
    logic [CW+SW-1:0]            hm_addr;
    logic                        hm_we;
    chan_ent_t                   ent_rd;
    chan_ent_t                   ent_new;
    logic                        full;
    logic [FW-1:0]               held;
    logic [WT_W-1:0]             wsum_new;
    logic                        out_free;
    logic                        accept;
    logic                        div_start;
    logic [WT_W-1:0]             div_quo;
    logic                        div_done;

    assign accept     = s_tvalid && s_tready;
    assign ch_ext     = XW'(ch_reg);
    assign ch_idx     = ch_ext[CW-1:0];
    assign ch_ok      = (32'(ch_reg) < CHANNELS);
    assign tick_phase = (state_reg == trm_pkg::ST_TICK_RD)
                     || (state_reg == trm_pkg::ST_TICK_CALC)
                     || (state_reg == trm_pkg::ST_TICK_DIV);
    assign cm_raddr   = tick_phase ? c_reg : ch_idx;
    assign cm_waddr   = tick_phase ? c_reg : ch_idx;
    assign hm_addr    = {c_reg, slot_reg};
    // an entry never written reads as all zero
    assign ent_rd     = vld_rd_reg ? cm_rd_reg : '0;
    assign full       = (fill_reg == FW'(WINDOW));
    assign held       = full ? FW'(WINDOW) : fill_reg + 1'b1;
    assign wsum_new   = ent_rd.wsum - (full ? WT_W'(hm_rd_reg) : '0) + WT_W'(ent_rd.count);
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == trm_pkg::ST_IDLE);

    trm_div #(
        .NUM_W (WT_W),
        .DEN_W (FW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (wsum_new),
        .den   (held),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_comb
    begin
        state_next    = state_reg;
        c_next        = c_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        open_next     = open_reg;
        tick_ent_next = tick_ent_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        res_next      = res_reg;
        cm_we         = 1'b0;
        cm_wdata      = ent_rd;
        hm_we         = 1'b0;
        div_start     = 1'b0;
        ent_new       = ent_rd;

        unique case (op_reg)
            trm_pkg::OP_ADD:
            begin
                ent_new.total = ent_rd.total + trm_pkg::TOTAL_W'(bytes_reg);
                ent_new.count = ent_rd.count + bytes_reg;
            end
            trm_pkg::OP_OPEN:
            begin
                if (open_reg != trm_pkg::CONN_MAX)
                begin
                    open_next = open_reg + 1'b1;
                end
            end
            trm_pkg::OP_CLOSE:
            begin
                if (open_reg != '0)
                begin
                    open_next = open_reg - 1'b1;
                end
            end
            trm_pkg::OP_TICK, trm_pkg::OP_QUERY:
            begin
            end
            default:
            begin
            end
        endcase

        unique case (state_reg)
            trm_pkg::ST_IDLE:
            begin
                open_next = open_reg;
                if (accept)
                begin
                    if (s_tdata[trm_pkg::OP_W-1:0] == trm_pkg::OP_TICK)
                    begin
                        c_next     = '0;
                        state_next = trm_pkg::ST_TICK_RD;
                    end
                    else
                    begin
                        state_next = trm_pkg::ST_READ;
                    end
                end
            end
            trm_pkg::ST_READ:
            begin
                open_next  = open_reg;
                state_next = trm_pkg::ST_EXEC;
            end
            trm_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    cm_we        = ch_ok && (op_reg == trm_pkg::OP_ADD);
                    cm_wdata     = ent_new;
                    m_valid_next = 1'b1;
                    res_next.total_bytes   = ch_ok ? ent_new.total : '0;
                    res_next.last_rate     = ch_ok ? ent_new.rate : '0;
                    res_next.average_speed = ch_ok ? ent_new.speed : '0;
                    res_next.connections   = open_next;
                    state_next   = trm_pkg::ST_IDLE;
                end
                else
                begin
                    open_next = open_reg;
                end
            end
            trm_pkg::ST_TICK_RD:
            begin
                open_next  = open_reg;
                state_next = trm_pkg::ST_TICK_CALC;
            end
            trm_pkg::ST_TICK_CALC:
            begin
                open_next           = open_reg;
                tick_ent_next       = ent_rd;
                tick_ent_next.count = '0;
                tick_ent_next.rate  = ent_rd.count;
                tick_ent_next.wsum  = wsum_new;
                hm_we               = 1'b1;
                div_start           = 1'b1;
                state_next          = trm_pkg::ST_TICK_DIV;
            end
            trm_pkg::ST_TICK_DIV:
            begin
                open_next = open_reg;
                if (div_done)
                begin
                    cm_we          = 1'b1;
                    cm_wdata       = tick_ent_reg;
                    cm_wdata.speed = div_quo[trm_pkg::RATE_W-1:0];
                    if (c_reg == CW'(CHANNELS - 1))
                    begin
                        fill_next  = held;
                        slot_next  = (slot_reg == SW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                        // report the selected channel like a query
                        state_next = trm_pkg::ST_READ;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = trm_pkg::ST_TICK_RD;
                    end
                end
            end
            default:
            begin
                open_next  = open_reg;
                state_next = trm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= trm_pkg::ST_IDLE;
            c_reg       <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            open_reg    <= '0;
            vld_reg     <= '0;
            vld_rd_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            c_reg       <= c_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            open_reg    <= open_next;
            vld_rd_reg  <= vld_reg[cm_raddr];
            m_valid_reg <= m_valid_next;
            if (cm_we)
            begin
                vld_reg[cm_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tdata[trm_pkg::OP_W-1:0];
            ch_reg    <= s_tdata[trm_pkg::OP_W +: trm_pkg::CH_W];
            bytes_reg <= s_tdata[trm_pkg::OP_W + trm_pkg::CH_W +: trm_pkg::BYTES_W];
        end
        tick_ent_reg <= tick_ent_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            chan_mem[cm_waddr] <= cm_wdata;
        end
        cm_rd_reg <= chan_mem[cm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hm_we)
        begin
            hist_mem[hm_addr] <= ent_rd.count;
        end
        hm_rd_reg <= hist_mem[hm_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

endmodule

// ===== dv/traffic_rate_meter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_rate_meter_test
// Self-checking bench for the traffic rate meter. Items go in on the slave
// stream. A model kept in the bench tracks totals, interval counts, the rate
// history and the connection count, and builds the expected result of each
// accepted item. Every result on the master stream is checked field by field
// against the oldest expected one. The sender idles in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module traffic_rate_meter_test;

    localparam int WINDOW       = 5;
    localparam int CHANNELS     = 4;
    localparam int MAX_GAP      = 12;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 200;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_ITEMS = 1600;
    localparam int EXP_DEPTH    = 16;

    localparam logic [trm_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [trm_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [trm_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic [trm_pkg::CH_W-1:0] CH_UP_RX = 2'd0;
    localparam logic [trm_pkg::CH_W-1:0] CH_UP_TX = 2'd1;
    localparam logic [trm_pkg::CH_W-1:0] CH_DN_RX = 2'd2;
    localparam logic [trm_pkg::CH_W-1:0] CH_DN_TX = 2'd3;

    localparam logic [trm_pkg::BYTES_W-1:0] BYTES_MAX = '1;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [trm_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [trm_pkg::OUT_W-1:0] m_tdata;

    // model state
    logic [trm_pkg::BYTES_W-1:0] pending_bytes [CHANNELS];
    logic [trm_pkg::TOTAL_W-1:0] byte_total    [CHANNELS];
    logic [trm_pkg::RATE_W-1:0]  tick_rate     [CHANNELS];
    logic [trm_pkg::RATE_W-1:0]  rate_log      [CHANNELS][WINDOW];
    logic [34:0]                 rate_sum      [CHANNELS];
    logic [trm_pkg::RATE_W-1:0]  avg_rate      [CHANNELS];
    int                          held_count;
    int                          write_slot;
    logic [trm_pkg::CONN_W-1:0]  conn_open;

    // expected results, oldest at exp_rd
    trm_pkg::result_t exp_buf [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;

    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int burst_left = 0;
    int stall_phase = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int ticks_sent = 0;

    always #10 clk = ~clk;

    traffic_rate_meter #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // advance the model by one item and queue the result it produces
    task automatic meter_update(input logic [trm_pkg::OP_W-1:0] op,
                                input logic [trm_pkg::CH_W-1:0] ch,
                                input logic [trm_pkg::BYTES_W-1:0] nbytes);
        bit               full;
        int               held;
        trm_pkg::result_t res;
        case (op)
            trm_pkg::OP_ADD:
            begin
                if (ch < CHANNELS)
                begin
                    byte_total[ch]    = byte_total[ch] + {32'd0, nbytes};
                    pending_bytes[ch] = pending_bytes[ch] + nbytes;
                end
            end
            trm_pkg::OP_TICK:
            begin
                full = (held_count >= WINDOW);
                held = full ? WINDOW : held_count + 1;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    tick_rate[c]     = pending_bytes[c];
                    pending_bytes[c] = '0;
                    if (full)
                        rate_sum[c] = rate_sum[c] - {3'd0, rate_log[c][write_slot]};
                    rate_log[c][write_slot] = tick_rate[c];
                    rate_sum[c] = rate_sum[c] + {3'd0, tick_rate[c]};
                    avg_rate[c] = trm_pkg::RATE_W'(64'(rate_sum[c]) / 64'(held));
                end
                held_count = held;
                write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
            end
            trm_pkg::OP_OPEN:
            begin
                if (conn_open != trm_pkg::CONN_MAX)
                    conn_open = conn_open + 1'b1;
            end
            trm_pkg::OP_CLOSE:
            begin
                if (conn_open != '0)
                    conn_open = conn_open - 1'b1;
            end
            default:
            begin
                // query and unused opcodes leave the state alone
            end
        endcase
        if (ch < CHANNELS)
        begin
            res.total_bytes   = byte_total[ch];
            res.last_rate     = tick_rate[ch];
            res.average_speed = avg_rate[ch];
        end
        else
        begin
            res.total_bytes   = '0;
            res.last_rate     = '0;
            res.average_speed = '0;
        end
        res.connections = conn_open;
        exp_buf[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
    endtask

    task automatic send_item(input logic [trm_pkg::OP_W-1:0] op,
                             input logic [trm_pkg::CH_W-1:0] ch,
                             input logic [trm_pkg::BYTES_W-1:0] nbytes);
        if (gaps_on && burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, nbytes, ch, op};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        meter_update(op, ch, nbytes);
        burst_left--;
        items_sent++;
        if (op == trm_pkg::OP_TICK)
            ticks_sent++;
    endtask

    // receiver: with stalls on, ready drops while stall_phase is 0 or 1, plus random drops
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
        if (!stalls_on)
            m_tready <= 1'b1;
        else
            m_tready <= (stall_phase > 1) && ($urandom_range(0, 3) != 0);
    end

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        trm_pkg::result_t got;
        trm_pkg::result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got = m_tdata;
            if (exp_wr == exp_rd)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                             $time, got);
            end
            else
            begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                report_field("total_bytes", want.total_bytes, got.total_bytes);
                report_field("last_rate", 64'(want.last_rate), 64'(got.last_rate));
                report_field("average_speed", 64'(want.average_speed),
                             64'(got.average_speed));
                report_field("connections", 64'(want.connections), 64'(got.connections));
                results_checked++;
            end
        end
    end

    // ends the run when neither stream moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("traffic_rate_meter verification failed");
        $finish;
    end

    task automatic test_idle_readout();
        send_item(trm_pkg::OP_QUERY, CH_UP_RX, BYTES_MAX);
        send_item(trm_pkg::OP_QUERY, CH_UP_TX, '0);
        send_item(trm_pkg::OP_QUERY, CH_DN_RX, 32'h5555_5555);
        send_item(trm_pkg::OP_QUERY, CH_DN_TX, 32'hAAAA_AAAA);
        // unused opcodes act as queries
        send_item(OP_UNUSED_LO, CH_UP_RX, BYTES_MAX);
        send_item(OP_UNUSED_MID, CH_DN_RX, 32'h1234_5678);
        send_item(OP_UNUSED_HI, CH_DN_TX, BYTES_MAX);
    endtask

    task automatic test_connection_floor();
        send_item(trm_pkg::OP_CLOSE, CH_UP_RX, '0);
        send_item(trm_pkg::OP_OPEN, CH_UP_TX, '0);
        send_item(trm_pkg::OP_CLOSE, CH_DN_TX, BYTES_MAX);
        send_item(trm_pkg::OP_CLOSE, CH_DN_RX, '0);
    endtask

    task automatic test_byte_extremes();
        send_item(trm_pkg::OP_ADD, CH_UP_RX, '0);
        // two full-scale adds wrap the interval count
        send_item(trm_pkg::OP_ADD, CH_UP_TX, BYTES_MAX);
        send_item(trm_pkg::OP_ADD, CH_UP_TX, BYTES_MAX);
        send_item(trm_pkg::OP_ADD, CH_DN_TX, BYTES_MAX);
        send_item(trm_pkg::OP_TICK, CH_DN_RX, BYTES_MAX);
        send_item(trm_pkg::OP_QUERY, CH_UP_TX, '0);
    endtask

    task automatic test_history_window();
        // more ticks than the window holds, near full-scale rates
        for (int i = 0; i < WINDOW + 2; i++)
        begin
            send_item(trm_pkg::OP_ADD, CH_DN_RX, BYTES_MAX - i);
            send_item(trm_pkg::OP_TICK, 2'(i), '0);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int                          pick;
        logic [trm_pkg::OP_W-1:0]    op;
        logic [trm_pkg::BYTES_W-1:0] nbytes;
        for (int i = 0; i < count; i++)
        begin
            // change the idling mix every quarter
            if (i % (count / 4) == 0)
            begin
                gaps_on   = (i / (count / 4)) % 2 == 0;
                stalls_on = (i / (count / 4)) < 2 ? gaps_on : !gaps_on;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = trm_pkg::OP_ADD;
            else if (pick < 63)
                op = trm_pkg::OP_TICK;
            else if (pick < 73)
                op = trm_pkg::OP_OPEN;
            else if (pick < 83)
                op = trm_pkg::OP_CLOSE;
            else if (pick < 93)
                op = trm_pkg::OP_QUERY;
            else
                op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            pick = $urandom_range(0, 9);
            if (pick < 3)
                nbytes = $urandom;
            else if (pick < 5)
                nbytes = BYTES_MAX - $urandom_range(0, 255);
            else
                nbytes = $urandom_range(0, 5000);
            send_item(op, 2'($urandom_range(0, 3)), nbytes);
        end
    endtask

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            pending_bytes[c] = '0;
            byte_total[c]    = '0;
            tick_rate[c]     = '0;
            rate_sum[c]      = '0;
            avg_rate[c]      = '0;
        end
        held_count = 0;
        write_slot = 0;
        conn_open  = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_readout();
        test_connection_floor();
        test_byte_extremes();
        test_history_window();
        test_random_traffic(RANDOM_ITEMS);
        s_tvalid <= 1'b0;

        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d items sent, %0d results checked, %0d interval ticks",
                 items_sent, results_checked, ticks_sent);
        $display("run: interval wrap, history roll-over, unused opcodes, connection floor");
        if (error_count == 0)
            $display("traffic_rate_meter verification clean");
        else
            $display("traffic_rate_meter verification failed");
        $finish;
    end

endmodule
